// ===== rtl/lpsc_pkg.sv =====
// Shared types, constants and helpers for the length-prefix to start-code converter.
`timescale 1ns / 1ps
package lpsc_pkg;

  // NAL header decoding
  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] H265_TYPE_MASK = 8'h7E;
  localparam logic [4:0] H264_SPS_TYPE  = 5'd7;
  localparam logic [5:0] H265_SPS_TYPE  = 6'd33;

  // Start code bytes: 00 00 00 then 01 in place of the last prefix byte
  localparam logic [7:0] START_ZERO_BYTE = 8'h00;
  localparam logic [7:0] START_LAST_BYTE = 8'h01;

  // Prefix byte index of the last length byte
  localparam logic [1:0] PREFIX_LAST_IDX = 2'd3;

  localparam int unsigned LEN_W   = 32;
  localparam int unsigned ACCUM_W = 24;

  typedef enum logic {
    CODEC_H264 = 1'b0,
    CODEC_H265 = 1'b1
  } codec_e;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_FIRST   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } item_t;

  // True when the first payload byte marks a sequence parameter set
  function automatic logic is_sps(input codec_e mode, input logic [7:0] b);
    logic [7:0] t264;
    logic [7:0] t265;
    t264 = b & H264_TYPE_MASK;
    t265 = (b & H265_TYPE_MASK) >> 1;
    if (mode == CODEC_H264) begin
      return t264[4:0] == H264_SPS_TYPE;
    end
    return t265[5:0] == H265_SPS_TYPE;
  endfunction

endpackage

// ===== rtl/lpsc_if.sv =====
// Stream interfaces for the converter's input and output channels.
`timescale 1ns / 1ps
interface lpsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface lpsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic       sps_found;
  logic       frame_error;

  modport source (output valid, output out_byte, output out_end, output sps_found,
                  output frame_error, input ready);
  modport sink   (input valid, input out_byte, input out_end, input sps_found,
                  input frame_error, output ready);
endinterface

// ===== rtl/lpsc_in_stage.sv =====
// Input register: captures one beat and hands it on when the core advances.
`timescale 1ns / 1ps
module lpsc_in_stage
  import lpsc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;

  // Free when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/lpsc_core.sv =====
// Conversion core: parse state, codec register and result register.
`timescale 1ns / 1ps
module lpsc_core
  import lpsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       advance_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_end_o,
  output logic       sps_found_o,
  output logic       frame_error_o
);

  codec_e               codec_q;
  phase_e               phase_q, phase_d;
  logic [1:0]           idx_q, idx_d;
  logic [ACCUM_W-1:0]   accum_q, accum_d;
  logic [LEN_W-1:0]     left_q, left_d;
  logic                 sps_q, sps_d;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           ob_q, ob_d;
  logic                 end_q;
  logic                 sps_out_q, sps_out_d;
  logic                 err_q, err_d;
  logic [LEN_W-1:0]     len;

  // Move the held beat when the result register is empty or being drained
  assign advance_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign len = {accum_q, item_i.data_byte};

  // Per-beat conversion
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    accum_d   = accum_q;
    left_d    = left_q;
    sps_d     = sps_q;
    ob_d      = item_i.data_byte;
    err_d     = 1'b0;
    sps_out_d = 1'b0;

    unique case (phase_q)
      PH_FIRST, PH_PAYLOAD: begin
        ob_d = item_i.data_byte;
        if (phase_q == PH_FIRST && is_sps(codec_q, item_i.data_byte)) begin
          sps_d = 1'b1;
        end
        left_d  = left_q - LEN_W'(1);
        phase_d = (left_d == '0) ? PH_PREFIX : PH_PAYLOAD;
      end
      default: begin
        // prefix byte; unused phase code lands here too
        phase_d = PH_PREFIX;
        if (idx_q != PREFIX_LAST_IDX) begin
          ob_d    = START_ZERO_BYTE;
          accum_d = {accum_q[ACCUM_W-9:0], item_i.data_byte};
          idx_d   = idx_q + 2'd1;
        end else begin
          ob_d    = START_LAST_BYTE;
          idx_d   = '0;
          accum_d = '0;
          if (len != '0) begin
            left_d  = len;
            phase_d = PH_FIRST;
          end
        end
      end
    endcase

    // Frame end: report flags, then clear the parse state
    if (item_i.frame_end) begin
      err_d     = (phase_d != PH_PREFIX) || (idx_d != '0);
      sps_out_d = sps_d;
      phase_d   = PH_PREFIX;
      idx_d     = '0;
      accum_d   = '0;
      left_d    = '0;
      sps_d     = 1'b0;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q     <= CODEC_H264;
      phase_q     <= PH_PREFIX;
      idx_q       <= '0;
      accum_q     <= '0;
      left_q      <= '0;
      sps_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        codec_q <= codec_e'(cfg_wdata_i);
      end
      if (advance_o) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        accum_q <= accum_d;
        left_q  <= left_d;
        sps_q   <= sps_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      ob_q      <= ob_d;
      end_q     <= item_i.frame_end;
      sps_out_q <= sps_out_d;
      err_q     <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = ob_q;
  assign out_end_o     = end_q;
  assign sps_found_o   = sps_out_q;
  assign frame_error_o = err_q;

endmodule

// ===== rtl/length_prefix_to_start_code.sv =====
// Top level of the length-prefix to start-code converter.
// An input beat passes through the input register, then the result register, to its output beat.
// Throughput: one byte per cycle while the output is not stalled; an empty input register
// takes a new beat while a result waits to be drained. The combinational parse update
// between the two registers sets the pace. Reset (rst_ni low, asynchronous) empties both
// registers, clears the parse state and sets the codec register to H.264.
`timescale 1ns / 1ps
module length_prefix_to_start_code
  import lpsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  lpsc_in_if.sink     in_i,
  lpsc_out_if.source  out_o,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i
);

  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  advance;
  logic  in_ready;

  assign in_item.data_byte = in_i.data_byte;
  assign in_item.frame_end = in_i.frame_end;
  assign in_i.ready        = in_ready;

  lpsc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_ready),
    .in_item_i    (in_item),
    .item_valid_o (held_valid),
    .advance_i    (advance),
    .item_o       (held_item)
  );

  lpsc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_valid_i  (held_valid),
    .item_i        (held_item),
    .advance_o     (advance),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .out_end_o     (out_o.out_end),
    .sps_found_o   (out_o.sps_found),
    .frame_error_o (out_o.frame_error)
  );

endmodule

// ===== rtl/lpsc_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
module lpsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_end_i,
  input logic       sps_found_i,
  input logic       frame_error_i
);

  // A stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_end_i)
      && $stable(sps_found_i) && $stable(frame_error_i))
    else $error("output payload changed while stalled");

  // Frame flags only show on the last beat of a frame
  a_flags_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_end_i |-> !sps_found_i && !frame_error_i)
    else $error("frame flags set outside frame end");

  // Input side never waits when the output side can move
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled while output free");

endmodule

bind length_prefix_to_start_code lpsc_checker u_lpsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_end_i     (out_o.out_end),
  .sps_found_i   (out_o.sps_found),
  .frame_error_i (out_o.frame_error)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the length-prefix to start-code converter.
`timescale 1ns / 1ps
module tb_top;
  import lpsc_pkg::*;

  // Output beat as predicted for one input byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       sps_found;
    logic       frame_error;
  } conv_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  lpsc_in_if  in_bus ();
  lpsc_out_if out_bus ();

  length_prefix_to_start_code i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Bytes waiting to be sent and converted beats waiting to come out
  item_t      src_bytes_q[$];
  conv_beat_t converted_q[$];

  // Predictor state
  codec_e      cfg_mode  = CODEC_H264;
  phase_e      prs_phase = PH_PREFIX;
  logic [1:0]  pfx_cnt   = '0;
  logic [23:0] len_acc   = '0;
  logic [31:0] nal_left  = '0;
  logic        sps_flag  = 1'b0;

  // Flow control knobs, percent chance per beat to start a burst
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned in_gap    = 0;
  int unsigned out_gap   = 0;
  bit          in_took   = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned gen_cnt      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // SPS test on the first payload byte under the current codec rule
  function automatic logic nal_is_sps(input logic [7:0] b);
    if (cfg_mode == CODEC_H264) begin
      return (b & H264_TYPE_MASK) == {3'b000, H264_SPS_TYPE};
    end
    return ((b & H265_TYPE_MASK) >> 1) == {2'b00, H265_SPS_TYPE};
  endfunction

  // Advance the parse state by one byte and return the converted beat
  function automatic conv_beat_t convert_byte(input logic [7:0] b, input logic last);
    conv_beat_t  r;
    logic [31:0] len;
    r = '0;
    if (prs_phase == PH_FIRST || prs_phase == PH_PAYLOAD) begin
      r.out_byte = b;
      if (prs_phase == PH_FIRST && !sps_flag && nal_is_sps(b)) begin
        sps_flag = 1'b1;
      end
      nal_left  = nal_left - 1;
      prs_phase = (nal_left == 0) ? PH_PREFIX : PH_PAYLOAD;
    end else begin
      prs_phase = PH_PREFIX;
      if (pfx_cnt != PREFIX_LAST_IDX) begin
        r.out_byte = START_ZERO_BYTE;
        len_acc    = {len_acc[15:0], b};
        pfx_cnt    = pfx_cnt + 2'd1;
      end else begin
        len        = {len_acc, b};
        r.out_byte = START_LAST_BYTE;
        pfx_cnt    = '0;
        len_acc    = '0;
        if (len != 0) begin
          nal_left  = len;
          prs_phase = PH_FIRST;
        end
      end
    end
    r.out_end = last;
    // Flags only count on the last byte; the frame then starts from scratch
    if (last) begin
      r.frame_error = (prs_phase != PH_PREFIX) || (pfx_cnt != 0);
      r.sps_found   = sps_flag;
      prs_phase     = PH_PREFIX;
      pfx_cnt       = '0;
      len_acc       = '0;
      nal_left      = '0;
      sps_flag      = 1'b0;
    end
    return r;
  endfunction

  // Input driver: valid holds until the beat is taken
  always @(negedge clk_i) begin
    if (!(in_bus.valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (src_bytes_q.size() > 0 && $urandom_range(99) < gap_pct) begin
        in_gap = $urandom_range(0, 17);
        in_bus.valid <= 1'b0;
      end else if (src_bytes_q.size() > 0) begin
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= src_bytes_q[0].data_byte;
        in_bus.frame_end <= src_bytes_q[0].frame_end;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // Output back-pressure
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_gap = $urandom_range(0, 17);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted input, compare accepted output
  always @(posedge clk_i) begin
    conv_beat_t exp_b;
    if (cfg_we_i) begin
      cfg_mode = codec_e'(cfg_wdata_i);
    end
    if (in_bus.valid && in_bus.ready) begin
      converted_q.push_back(convert_byte(in_bus.data_byte, in_bus.frame_end));
      void'(src_bytes_q.pop_front());
      in_took = 1'b1;
    end
    if (out_bus.valid && out_bus.ready) begin
      if (converted_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat byte=%02h end=%b sps=%b err=%b", $time,
                 out_bus.out_byte, out_bus.out_end, out_bus.sps_found, out_bus.frame_error);
      end else begin
        exp_b = converted_q.pop_front();
        if (out_bus.out_byte !== exp_b.out_byte || out_bus.out_end !== exp_b.out_end ||
            out_bus.sps_found !== exp_b.sps_found ||
            out_bus.frame_error !== exp_b.frame_error) begin
          mismatch_cnt++;
          $display("%0t: mismatch expected byte=%02h end=%b sps=%b err=%b", $time,
                   exp_b.out_byte, exp_b.out_end, exp_b.sps_found, exp_b.frame_error);
          $display("%0t:          actual   byte=%02h end=%b sps=%b err=%b", $time,
                   out_bus.out_byte, out_bus.out_end, out_bus.sps_found,
                   out_bus.frame_error);
        end
      end
    end
  end

  // Queue one frame, frame_end on its last byte
  task automatic push_frame(input logic [7:0] bytes[$]);
    item_t it;
    foreach (bytes[k]) begin
      it.data_byte = bytes[k];
      it.frame_end = (k == bytes.size() - 1);
      src_bytes_q.push_back(it);
    end
    gen_cnt += bytes.size();
  endtask

  // NAL header byte: an SPS under either rule, or anything
  function automatic logic [7:0] nal_head();
    case ($urandom_range(0, 2))
      0:       return {3'($urandom), H264_SPS_TYPE};
      1:       return {1'($urandom), H265_SPS_TYPE, 1'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  // Random frame: mostly well formed, some cut short, some pure noise
  task automatic gen_frame();
    logic [7:0]  fb[$];
    int unsigned kind;
    int unsigned roll;
    int unsigned len;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 10)) fb.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          len = 0;
        end else if (roll < 15) begin
          len = $urandom_range(13, 80);
        end else begin
          len = $urandom_range(1, 12);
        end
        fb.push_back(8'(len >> 24));
        fb.push_back(8'(len >> 16));
        fb.push_back(8'(len >> 8));
        fb.push_back(8'(len));
        for (int k = 0; k < len; k++) begin
          fb.push_back((k == 0) ? nal_head() : 8'($urandom));
        end
      end
      // Truncate to end inside a prefix or a payload
      if (kind >= 80) begin
        cut = $urandom_range(1, fb.size() - 1);
        while (fb.size() > cut) fb.delete(fb.size() - 1);
      end
    end
    push_frame(fb);
  endtask

  task automatic wait_drained();
    while (src_bytes_q.size() != 0 || converted_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_codec(input codec_e m);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_frames(input int unsigned n_bytes);
    gen_cnt = 0;
    while (gen_cnt < n_bytes) gen_frame();
  endtask

  // Main sequence
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.frame_end  = 1'b0;
    out_bus.ready     = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // H.264 after reset: zero-length NAL, SPS, cut prefix, cut payload, mixed
    gap_pct   = 10;
    stall_pct = 10;
    push_frame('{8'h00, 8'h00, 8'h00, 8'h00});
    push_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'h67});
    push_frame('{8'hFF});
    push_frame('{8'h00, 8'h00, 8'h00, 8'h02, 8'hE7});
    push_frame('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF});
    random_frames(210);
    wait_drained();

    // H.265 rule, sender-side gaps dominate
    write_codec(CODEC_H265);
    gap_pct   = 20;
    stall_pct = 3;
    push_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'h42});
    push_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'h67});
    random_frames(210);
    wait_drained();

    // Back to H.264, heavy back-pressure
    write_codec(CODEC_H264);
    gap_pct   = 3;
    stall_pct = 20;
    random_frames(210);
    wait_drained();

    write_codec(CODEC_H265);
    gap_pct   = 10;
    stall_pct = 10;
    random_frames(210);
    wait_drained();

    // Final stretch at full rate
    write_codec(CODEC_H264);
    gap_pct   = 0;
    stall_pct = 0;
    random_frames(210);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lpsc_pkg.sv
rtl/lpsc_if.sv
rtl/lpsc_in_stage.sv
rtl/lpsc_core.sv
rtl/length_prefix_to_start_code.sv
rtl/lpsc_checker.sv
sim/tb_top.sv
